[design/rlf_pkg.sv]
// Package for the RGB linear fader: word types, control struct and constants.
// No dependencies; imported by rlf_channel and rgb_linear_fader.
package rlf_pkg;

    localparam int LEVEL_W = 8;
    // Signed step accumulator: holds diff * step with |diff| <= 255, step <= 256.
    localparam int ACC_W = 17;
    // Quotient bits kept from the reciprocal multiply; the magnitude never exceeds a level.
    localparam int QUOT_W = 8;
    // Fraction bits of the reciprocal; exact floor for dividends below 2^17.
    localparam int RECIP_SHIFT = 26;

    localparam logic [LEVEL_W-1:0] DELAY_RESET = 8'd2;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_FADE = 1'b1
    } op_t;

    typedef struct packed {
        op_t                operation;
        logic [LEVEL_W-1:0] new_red;
        logic [LEVEL_W-1:0] new_green;
        logic [LEVEL_W-1:0] new_blue;
    } in_word_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] out_red;
        logic [LEVEL_W-1:0] out_green;
        logic [LEVEL_W-1:0] out_blue;
        logic               fading;
    } out_word_t;

    // Per-cycle commands from the fade sequencer to each channel.
    typedef struct packed {
        logic load;     // latch start and goal, restart the accumulator
        logic advance;  // take one fade step
        logic snap;     // final step: jump to the goal
    } ctrl_t;

endpackage

[design/rlf_channel.sv]
// One color channel of the fader: level, start, goal and step accumulator,
// with the floor division by the step count done as a reciprocal multiply.
// Depends on rlf_pkg.
module rlf_channel
    import rlf_pkg::*;
#(
    parameter int FADE_STEPS = 100
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_t              ctrl,
    input  logic [LEVEL_W-1:0] new_level,
    output logic [LEVEL_W-1:0] level_next,
    output logic               matches_new
);

    localparam int RECIP_W = RECIP_SHIFT + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(FADE_STEPS) - 64'd1) / 64'(FADE_STEPS));
    localparam logic [ACC_W-1:0] ROUND_UP = ACC_W'(FADE_STEPS - 1);
    localparam int PROD_W = ACC_W + RECIP_W;

    logic [LEVEL_W-1:0]      level_reg;
    logic [LEVEL_W-1:0]      start_reg;
    logic [LEVEL_W-1:0]      goal_reg;
    logic signed [ACC_W-1:0] acc_reg;     // diff * (step about to be taken)
    logic signed [ACC_W-1:0] acc_next;

    logic signed [ACC_W-1:0] diff;
    logic                    acc_neg;
    logic [ACC_W-1:0]        dividend;
    logic [PROD_W-1:0]       prod;
    logic [QUOT_W-1:0]       quot;
    logic [LEVEL_W-1:0]      interp;

    assign matches_new = (new_level == level_reg);

    // Step difference of the running fade
    assign diff = $signed({{(ACC_W-LEVEL_W){1'b0}}, goal_reg})
                - $signed({{(ACC_W-LEVEL_W){1'b0}}, start_reg});

    // Floor division of the accumulator: ceil of the magnitude when negative
    assign acc_neg  = acc_reg[ACC_W-1];
    assign dividend = acc_neg ? ((-acc_reg) + ROUND_UP) : acc_reg;
    assign prod     = PROD_W'(dividend) * PROD_W'(RECIP);
    assign quot     = prod[RECIP_SHIFT +: QUOT_W];
    assign interp   = acc_neg ? (start_reg - quot) : (start_reg + quot);

    // Select next level and accumulator
    always_comb
    begin
        level_next = level_reg;
        acc_next   = acc_reg;
        if (ctrl.load)
        begin
            acc_next = $signed({{(ACC_W-LEVEL_W){1'b0}}, new_level})
                     - $signed({{(ACC_W-LEVEL_W){1'b0}}, level_reg});
        end
        else if (ctrl.advance)
        begin
            level_next = ctrl.snap ? goal_reg : interp;
            acc_next   = acc_reg + diff;
        end
    end

    // Hold channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            start_reg <= '0;
            goal_reg  <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            level_reg <= level_next;
            acc_reg   <= acc_next;
            if (ctrl.load)
            begin
                start_reg <= level_reg;
                goal_reg  <= new_level;
            end
        end
    end

endmodule

[design/rgb_linear_fader.sv]
// RGB linear fader top level: input register, fade sequencer, three channels
// and the result register. Depends on rlf_pkg and rlf_channel.
//
// A word accepted into the input register moves into the result register when that
// register is empty or being taken, and its result word is then offered there.
// Throughput: one word per cycle while out_stall is low; input and result register decouple
// the two channels, and each word's state update is one pass through a channel.
// Reset: levels, start, goal, counters and fade flag clear; step_delay is 2.
module rgb_linear_fader
    import rlf_pkg::*;
#(
    parameter int FADE_STEPS = 100
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [LEVEL_W-1:0] cfg_write_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  in_word_t           in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output out_word_t          out_word
);

    localparam logic [LEVEL_W:0] STEPS_LAST = (LEVEL_W+1)'(FADE_STEPS);

    logic [LEVEL_W-1:0] step_delay_reg;
    logic               in_valid_reg;
    in_word_t           in_word_reg;
    logic               out_valid_reg;
    out_word_t          out_word_reg;
    logic               active_reg;
    logic               active_next;
    logic [LEVEL_W-1:0] step_count_reg;
    logic [LEVEL_W-1:0] step_count_next;
    logic [LEVEL_W-1:0] wait_count_reg;
    logic [LEVEL_W-1:0] wait_count_next;

    logic               out_free;
    logic               accept;
    logic               process;
    logic               all_match;
    logic               tick;
    logic [LEVEL_W:0]   step_inc;
    ctrl_t              ctrl;

    logic [LEVEL_W-1:0] next_r, next_g, next_b;
    logic               match_r, match_g, match_b;

    // Handshake: advance when the result register is empty or being taken
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = in_valid_reg && !out_free;
    assign accept    = in_valid && !in_stall;
    assign process   = in_valid_reg && out_free;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // Fade sequencer
    assign all_match = match_r && match_g && match_b;
    assign tick      = process && (in_word_reg.operation == OP_TICK) && active_reg;
    assign step_inc  = {1'b0, step_count_reg} + 1'b1;

    always_comb
    begin
        ctrl            = '0;
        active_next     = active_reg;
        step_count_next = step_count_reg;
        wait_count_next = wait_count_reg;
        if (process && (in_word_reg.operation == OP_FADE) && !all_match)
        begin
            ctrl.load       = 1'b1;
            active_next     = 1'b1;
            step_count_next = '0;
            wait_count_next = step_delay_reg;
        end
        else if (tick)
        begin
            if (wait_count_reg == '0)
            begin
                ctrl.advance    = 1'b1;
                ctrl.snap       = (step_inc >= STEPS_LAST);
                active_next     = !ctrl.snap;
                step_count_next = step_inc[LEVEL_W-1:0];
                wait_count_next = step_delay_reg;
            end
            else
            begin
                wait_count_next = wait_count_reg - 1'b1;
            end
        end
    end

    rlf_channel #(.FADE_STEPS(FADE_STEPS)) u_red (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .new_level   (in_word_reg.new_red),
        .level_next  (next_r),
        .matches_new (match_r)
    );

    rlf_channel #(.FADE_STEPS(FADE_STEPS)) u_green (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .new_level   (in_word_reg.new_green),
        .level_next  (next_g),
        .matches_new (match_g)
    );

    rlf_channel #(.FADE_STEPS(FADE_STEPS)) u_blue (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .new_level   (in_word_reg.new_blue),
        .level_next  (next_b),
        .matches_new (match_b)
    );

    // Configuration: drop zero writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_delay_reg <= DELAY_RESET;
        end
        else if (cfg_write_en && (cfg_write_data != '0))
        begin
            step_delay_reg <= cfg_write_data;
        end
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            step_count_reg <= '0;
            wait_count_reg <= '0;
        end
        else
        begin
            active_reg     <= active_next;
            step_count_reg <= step_count_next;
            wait_count_reg <= wait_count_next;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (process)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_word_reg <= in_word;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (process)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            out_word_reg.out_red   <= next_r;
            out_word_reg.out_green <= next_g;
            out_word_reg.out_blue  <= next_b;
            out_word_reg.fading    <= active_next;
        end
    end

endmodule

[dv/fade_level_checker.sv]
`timescale 1ns / 100ps
// Fade level checker: tracks the fader's levels, step timing and delay setting,
// predicts every result word and compares it with what the block returns. Uses rlf_pkg.
module fade_level_checker
    import rlf_pkg::*;
#(
    parameter int FADE_STEPS = 100
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [LEVEL_W-1:0] cfg_write_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  in_word_t           in_word,
    input  logic               out_valid,
    input  logic               out_stall,
    input  out_word_t          out_word,
    output int                 mismatches,
    output int                 pending,
    output int                 checked,
    output int                 fades_done
);

    typedef logic [LEVEL_W-1:0] level_t;

    level_t    delay_setting;
    level_t    cur_r, cur_g, cur_b;
    level_t    from_r, from_g, from_b;
    level_t    to_r, to_g, to_b;
    level_t    step_no;
    level_t    wait_left;
    logic      in_fade;
    out_word_t expected_levels[$];

    // Level part way along a ramp; the quotient rounds toward minus infinity
    function automatic level_t ramp_level(level_t from, level_t to, level_t step);
        int span;
        int scaled;
        int share;
        span   = int'(to) - int'(from);
        scaled = span * int'(step);
        if (scaled >= 0)
            share = scaled / FADE_STEPS;
        else
            share = (scaled - (FADE_STEPS - 1)) / FADE_STEPS;
        return level_t'(int'(from) + share);
    endfunction

    // Apply one input word to the tracked state and return the levels after it
    function automatic out_word_t advance_fader(in_word_t w);
        out_word_t res;
        if (w.operation == OP_FADE) begin
            // retarget only when the goal differs from where the levels stand
            if (w.new_red != cur_r || w.new_green != cur_g || w.new_blue != cur_b) begin
                from_r    = cur_r;
                from_g    = cur_g;
                from_b    = cur_b;
                to_r      = w.new_red;
                to_g      = w.new_green;
                to_b      = w.new_blue;
                wait_left = delay_setting;
                step_no   = '0;
                in_fade   = 1'b1;
            end
        end
        else if (in_fade) begin
            if (wait_left == '0) begin
                step_no = step_no + 1'b1;
                if (int'(step_no) >= FADE_STEPS) begin
                    // final step: land exactly on the goal
                    cur_r   = to_r;
                    cur_g   = to_g;
                    cur_b   = to_b;
                    in_fade = 1'b0;
                    fades_done++;
                end
                else begin
                    cur_r = ramp_level(from_r, to_r, step_no);
                    cur_g = ramp_level(from_g, to_g, step_no);
                    cur_b = ramp_level(from_b, to_b, step_no);
                end
                wait_left = delay_setting;
            end
            else begin
                wait_left = wait_left - 1'b1;
            end
        end
        res.out_red   = cur_r;
        res.out_green = cur_g;
        res.out_blue  = cur_b;
        res.fading    = in_fade;
        return res;
    endfunction

    // Watch both channels and the register port
    always @(posedge clk or negedge rst_n) begin
        out_word_t want;
        if (!rst_n) begin
            delay_setting = DELAY_RESET;
            cur_r = '0;  cur_g = '0;  cur_b = '0;
            from_r = '0; from_g = '0; from_b = '0;
            to_r = '0;   to_g = '0;   to_b = '0;
            step_no   = '0;
            wait_left = '0;
            in_fade   = 1'b0;
            expected_levels.delete();
            mismatches = 0;
            pending    = 0;
            checked    = 0;
            fades_done = 0;
        end
        else begin
            // hold the delay; a zero write leaves it as it was
            if (cfg_write_en && cfg_write_data != '0)
                delay_setting = cfg_write_data;

            // compare a returned word with the oldest prediction
            if (out_valid && !out_stall) begin
                if (expected_levels.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result word: expected none, ", $time,
                             "got r=%0d g=%0d b=%0d fading=%0b",
                             out_word.out_red, out_word.out_green, out_word.out_blue,
                             out_word.fading);
                end
                else begin
                    want = expected_levels.pop_front();
                    checked++;
                    if (out_word.out_red   !== want.out_red   ||
                        out_word.out_green !== want.out_green ||
                        out_word.out_blue  !== want.out_blue  ||
                        out_word.fading    !== want.fading) begin
                        mismatches++;
                        $display("%0t: result word %0d: ", $time, checked,
                                 "expected r=%0d g=%0d b=%0d fading=%0b, ",
                                 want.out_red, want.out_green, want.out_blue,
                                 want.fading,
                                 "got r=%0d g=%0d b=%0d fading=%0b",
                                 out_word.out_red, out_word.out_green,
                                 out_word.out_blue, out_word.fading);
                    end
                end
            end

            // predict the result of an accepted input word
            if (in_valid && !in_stall)
                expected_levels.push_back(advance_fader(in_word));

            pending = expected_levels.size();
        end
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// Testbench top for rgb_linear_fader: clock, reset, word and register stimulus
// with random idling; checking lives in fade_level_checker. Uses rlf_pkg.
module testbench
    import rlf_pkg::*;
();

    localparam int FADE_STEPS  = 100;
    localparam int ITEM_TARGET = 1150;

    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               cfg_write_en   = 1'b0;
    logic [LEVEL_W-1:0] cfg_write_data = '0;
    logic               in_valid       = 1'b0;
    logic               in_stall;
    in_word_t           in_word        = '0;
    logic               out_valid;
    logic               out_stall      = 1'b0;
    out_word_t          out_word;

    int mismatches;
    int pending;
    int checked;
    int fades_done;

    logic               calm          = 1'b0;
    int                 stall_left    = 0;
    int                 words_sent    = 0;
    int                 commands_sent = 0;
    int                 ticks_sent    = 0;
    logic [LEVEL_W-1:0] delay_now     = DELAY_RESET;
    logic [LEVEL_W-1:0] last_r        = '0;
    logic [LEVEL_W-1:0] last_g        = '0;
    logic [LEVEL_W-1:0] last_b        = '0;

    rgb_linear_fader #(
        .FADE_STEPS (FADE_STEPS)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_word        (in_word),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_word       (out_word)
    );

    fade_level_checker #(
        .FADE_STEPS (FADE_STEPS)
    ) levels_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_word        (in_word),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_word       (out_word),
        .mismatches     (mismatches),
        .pending        (pending),
        .checked        (checked),
        .fades_done     (fades_done)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Stop a hung run
    initial
    begin
        #10000000;
        $display("rgb_linear_fader: mismatch");
        $finish;
    end

    // Switch between stretches with idling and stretches without
    always @(negedge clk)
    begin
        if ($urandom_range(0, 299) == 0)
            calm <= ~calm;
    end

    // Drive out_stall: mostly open, short holds, now and then a long one
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (!calm && $urandom_range(0, 9) < 3)
            stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 3);
        out_stall <= (stall_left > 0);
    end

    function automatic int pick_gap();
        if (calm || $urandom_range(0, 9) < 6)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // Favor the ends of the level range
    function automatic logic [LEVEL_W-1:0] pick_level();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return LEVEL_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Present one word after a random gap and hold it until accepted
    task automatic send_word(in_word_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
    endtask

    task automatic send_fade(logic [LEVEL_W-1:0] r, logic [LEVEL_W-1:0] g,
                             logic [LEVEL_W-1:0] b);
        in_word_t w;
        w.operation = OP_FADE;
        w.new_red   = r;
        w.new_green = g;
        w.new_blue  = b;
        last_r = r;
        last_g = g;
        last_b = b;
        commands_sent++;
        send_word(w);
    endtask

    // Tick words carry random levels that the block must ignore
    task automatic send_tick();
        in_word_t w;
        w.operation = OP_TICK;
        w.new_red   = LEVEL_W'($urandom_range(0, 255));
        w.new_green = LEVEL_W'($urandom_range(0, 255));
        w.new_blue  = LEVEL_W'($urandom_range(0, 255));
        ticks_sent++;
        send_word(w);
    endtask

    // Drop valid, wait out every pending result and the pipeline behind it
    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_delay(logic [LEVEL_W-1:0] value);
        drain();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        if (value != '0)
            delay_now = value;
    endtask

    // Fade commands each followed by a run of ticks: short ones cut the fade,
    // long ones carry it through to the goal
    task automatic run_phase(int budget);
        int stop_at;
        int full;
        int span;
        stop_at = words_sent + budget;
        full    = (int'(delay_now) + 1) * FADE_STEPS + 1;
        while (words_sent < stop_at)
        begin
            // repeat the last goal now and then: a no-op once that fade has ended
            if ($urandom_range(0, 3) == 0)
                send_fade(last_r, last_g, last_b);
            else
                send_fade(pick_level(), pick_level(), pick_level());
            case ($urandom_range(0, 9)) inside
                [0:2]:   span = $urandom_range(0, 20);
                [3:5]:   span = $urandom_range(1, full);
                default: span = $urandom_range(full, full + 30);
            endcase
            repeat (span)
            begin
                if (words_sent < stop_at)
                    send_tick();
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle tick, no-op goal, steps, no-op mid-fade, restart downward
        send_tick();
        send_fade(8'd0, 8'd0, 8'd0);
        send_fade(8'd255, 8'd255, 8'd255);
        repeat (3) send_tick();
        send_fade(8'd2, 8'd2, 8'd2);
        repeat (3) send_tick();
        send_fade(8'd0, 8'd128, 8'd255);
        repeat (6) send_tick();
        send_fade(8'd255, 8'd0, 8'd255);
        repeat (3) send_tick();

        // Fastest stepping: full fades run to their goal
        write_delay(8'd1);
        run_phase(450);

        // A zero write is dropped, so stepping stays at its fastest
        write_delay(8'd0);
        run_phase(40);

        // Slowest stepping
        write_delay(8'd255);
        run_phase(280);

        // Small random delays until the item count is reached
        while (words_sent < ITEM_TARGET)
        begin
            write_delay(LEVEL_W'($urandom_range(1, 8)));
            run_phase((ITEM_TARGET - words_sent < 120) ? ITEM_TARGET - words_sent : 120);
        end

        drain();
        $display("run covered %0d checked words: %0d fade commands, ",
                 checked, commands_sent,
                 "%0d ticks, %0d fades to goal", ticks_sent, fades_done);
        $display("step delays: reset value, 1, 255, small random ones and an ignored zero write");
        if (mismatches == 0 && pending == 0)
            $display("rgb_linear_fader: match");
        else
            $display("rgb_linear_fader: mismatch");
        $finish;
    end

endmodule

[sim.f]
design/rlf_pkg.sv
design/rlf_channel.sv
design/rgb_linear_fader.sv
dv/fade_level_checker.sv
dv/testbench.sv
